// File: hw/rtl/expr_lex_pkg.sv
// Shared types, character codes and token kinds for the expression lexer.
// No dependencies; used by expression_lexer_top.
`default_nettype none

package expr_lex_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_req_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_req_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LABEL  = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  localparam logic [4:0] KIND_NONE   = 5'd0;
  localparam logic [4:0] KIND_LABEL  = 5'd0;
  localparam logic [4:0] KIND_NUMBER = 5'd1;
  localparam logic [4:0] KIND_LPAREN = 5'd2;
  localparam logic [4:0] KIND_LT     = 5'd3;
  localparam logic [4:0] KIND_LBRACK = 5'd4;
  localparam logic [4:0] KIND_LBRACE = 5'd5;
  localparam logic [4:0] KIND_RPAREN = 5'd6;
  localparam logic [4:0] KIND_GT     = 5'd7;
  localparam logic [4:0] KIND_RBRACK = 5'd8;
  localparam logic [4:0] KIND_RBRACE = 5'd9;
  localparam logic [4:0] KIND_EQ     = 5'd10;
  localparam logic [4:0] KIND_DOT    = 5'd11;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd13;
  localparam logic [4:0] KIND_STAR   = 5'd14;
  localparam logic [4:0] KIND_SLASH  = 5'd15;
  localparam logic [4:0] KIND_BANG   = 5'd16;
  localparam logic [4:0] KIND_COMMA  = 5'd17;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_DIG_0) && (ch <= CH_DIG_9);
  endfunction

  // KIND_NONE for anything that is not single-byte punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] ch);
    logic [4:0] k;
    case (ch)
      CH_LPAREN: k = KIND_LPAREN;
      CH_LT:     k = KIND_LT;
      CH_LBRACK: k = KIND_LBRACK;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RPAREN: k = KIND_RPAREN;
      CH_GT:     k = KIND_GT;
      CH_RBRACK: k = KIND_RBRACK;
      CH_RBRACE: k = KIND_RBRACE;
      CH_EQ:     k = KIND_EQ;
      CH_DOT:    k = KIND_DOT;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_BANG:   k = KIND_BANG;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/expression_lexer_top.sv
// Expression lexer top level: byte classification, token state and result queue.
// Depends on expr_lex_pkg (types, character codes, token kinds).
//
// Usage:
//   char channel (char_valid/char_ready/char_req) takes one text byte per
//   request, with an end_of_text flag on the last byte of a text.
//   tok channel (tok_valid/tok_ready/tok_req) gives tokens as kind, start
//   position, length and a flag on the last token caused by one byte.
// Timing:
//   A byte is classified in the cycle it is accepted; its tokens (0, 1 or 2)
//   are written into a four-entry result queue register and show on tok_req,
//   one token per cycle while tok_ready is high. Bytes are taken one per
//   cycle while the queue has room for two tokens, so the rate is one byte per
//   cycle as long as the receiver takes at least one token per byte on average.
// Stalls:
//   When tok_ready is low the head token holds; once fewer than two queue
//   slots are free, char_ready drops until the receiver drains.
// Reset:
//   rst clears the scan state, position counter and queue; the next byte
//   is position 0 of a new text.
`default_nettype none

module expression_lexer_top #(
  parameter int POS_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         char_valid,
  output logic                        char_ready,
  input  wire expr_lex_pkg::char_req_t char_req,
  output logic                        tok_valid,
  input  wire                         tok_ready,
  output expr_lex_pkg::tok_req_t       tok_req
);

  localparam int WIDE   = (POS_BITS > 16) ? POS_BITS : 16;
  localparam int QDEPTH = 4;
  localparam int QPTR   = 2;

  // scan state
  expr_lex_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic [POS_BITS-1:0] pending_start, pending_start_next;
  logic [POS_BITS-1:0] pending_length, pending_length_next;
  logic [POS_BITS-1:0] byte_position, byte_position_next;

  // result queue
  expr_lex_pkg::tok_req_t queue [QDEPTH];
  logic [QPTR-1:0] wr_ptr;
  logic [QPTR-1:0] rd_ptr;
  logic [QPTR:0]   count;

  logic accept;
  logic pop;
  logic [7:0] ch;
  logic eot;
  logic ch_letter, ch_digit, cont, flush_a, punct_hit, flush_b;
  logic [4:0] pkind;
  logic [4:0] kind_a, kind_b;
  logic [1:0] n_res;
  expr_lex_pkg::tok_req_t res_a, res_b, res_p, res_first, res_second;

  function automatic expr_lex_pkg::tok_req_t make_tok(
    input logic [4:0]          kind,
    input logic [POS_BITS-1:0] start,
    input logic [POS_BITS-1:0] len
  );
    expr_lex_pkg::tok_req_t t;
    logic [WIDE-1:0] start_w;
    logic [WIDE-1:0] len_w;
    start_w = WIDE'(start);
    len_w   = WIDE'(len);
    t.token_kind   = kind;
    t.token_start  = start_w[15:0];
    t.token_length = (len_w > WIDE'(16'hFFFF)) ? 16'hFFFF : len_w[15:0];
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign char_ready = (count <= (QPTR+1)'(QDEPTH - 2));
  assign accept     = char_valid && char_ready;
  assign tok_valid  = (count != '0);
  assign pop        = tok_valid && tok_ready;
  assign tok_req    = queue[rd_ptr];

  assign ch        = char_req.char_code;
  assign eot       = char_req.end_of_text;
  assign ch_letter = expr_lex_pkg::is_letter(ch);
  assign ch_digit  = expr_lex_pkg::is_digit(ch);
  assign pkind     = expr_lex_pkg::punct_kind(ch);

  always_comb begin
    scan_mode_next      = scan_mode;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    cont                = 1'b0;
    flush_a             = 1'b0;
    punct_hit           = 1'b0;
    flush_b             = 1'b0;
    kind_a              = expr_lex_pkg::KIND_NUMBER;
    kind_b              = expr_lex_pkg::KIND_NUMBER;

    // does the byte extend the pending token, or end it?
    case (scan_mode)
      expr_lex_pkg::MODE_LABEL: begin
        cont    = ch_letter || ch_digit || (ch == expr_lex_pkg::CH_UNDER);
        flush_a = !cont;
        kind_a  = expr_lex_pkg::KIND_LABEL;
      end
      expr_lex_pkg::MODE_NUMBER: begin
        cont    = ch_digit || (ch == expr_lex_pkg::CH_DOT);
        flush_a = !cont;
        kind_a  = expr_lex_pkg::KIND_NUMBER;
      end
      default: begin
        cont    = 1'b0;
        flush_a = 1'b0;
      end
    endcase

    // byte handled again from idle when not absorbed
    if (cont) begin
      if (pending_length != '1) begin
        pending_length_next = pending_length + POS_BITS'(1);
      end
    end else if (ch_letter) begin
      scan_mode_next      = expr_lex_pkg::MODE_LABEL;
      pending_start_next  = byte_position;
      pending_length_next = POS_BITS'(1);
    end else if (ch_digit) begin
      scan_mode_next      = expr_lex_pkg::MODE_NUMBER;
      pending_start_next  = byte_position;
      pending_length_next = POS_BITS'(1);
    end else begin
      scan_mode_next = expr_lex_pkg::MODE_IDLE;
      punct_hit      = (pkind != expr_lex_pkg::KIND_NONE);
    end

    if (eot) begin
      flush_b = (scan_mode_next != expr_lex_pkg::MODE_IDLE);
      kind_b  = (scan_mode_next == expr_lex_pkg::MODE_LABEL) ?
                expr_lex_pkg::KIND_LABEL : expr_lex_pkg::KIND_NUMBER;
      scan_mode_next     = expr_lex_pkg::MODE_IDLE;
      byte_position_next = '0;
    end else begin
      byte_position_next = byte_position + POS_BITS'(1);
    end

    res_a = make_tok(kind_a, pending_start, pending_length);
    res_p = make_tok(pkind, byte_position, POS_BITS'(1));
    res_b = make_tok(kind_b, pending_start_next, pending_length_next);

    // at most two of the three candidates fire; pack them in order
    res_first  = flush_a ? res_a : (punct_hit ? res_p : res_b);
    res_second = (flush_a && punct_hit) ? res_p : res_b;
    n_res      = 2'(flush_a) + 2'(punct_hit) + 2'(flush_b);
    res_first.last_of_run  = (n_res == 2'd1);
    res_second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= expr_lex_pkg::MODE_IDLE;
      pending_start  <= '0;
      pending_length <= '0;
      byte_position  <= '0;
    end else if (accept) begin
      scan_mode      <= scan_mode_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      byte_position  <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res_first;
    end
    if (accept && (n_res == 2'd2)) begin
      queue[wr_ptr + QPTR'(1)] <= res_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTR'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR'(1);
      end
      count <= count + (accept ? (QPTR+1)'(n_res) : '0) - (QPTR+1)'(pop);
    end
  end

endmodule

`default_nettype wire
